[sv/pesr_pkg.sv]
// Package: shared types, codes and constants of the PES packet reassembler.
`timescale 1ns / 1ps

package pesr_pkg;

  localparam int unsigned OFF_W      = 17;
  localparam int unsigned HDR_SIZE   = 9;
  localparam int unsigned HDR_IDX_W  = 4;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_AW       = 2;

  // Stream ids without the optional PES header
  localparam logic [7:0] SID_PROG_MAP  = 8'hBC;
  localparam logic [7:0] SID_PADDING   = 8'hBE;
  localparam logic [7:0] SID_PRIV2     = 8'hBF;
  localparam logic [7:0] SID_ECM       = 8'hF0;
  localparam logic [7:0] SID_EMM       = 8'hF1;
  localparam logic [7:0] SID_DSMCC     = 8'hF2;
  localparam logic [7:0] SID_H222_E    = 8'hF8;
  localparam logic [7:0] SID_PROG_DIR  = 8'hFF;

  localparam logic [7:0] START_CODE_LAST = 8'h01;
  localparam logic [7:0] MARKER_MASK     = 8'hC0;
  localparam logic [7:0] MARKER_VALUE    = 8'h80;
  localparam logic [7:0] SCRAMBLE_MASK   = 8'h30;
  localparam logic [1:0] PTS_DTS_FORBIDDEN = 2'b01;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        byte_out;
    logic [OFF_W-1:0]  byte_offset;
    logic [7:0]        stream_ident;
    logic [15:0]       declared_length;
    logic              has_optional_header;
    logic [1:0]        pts_dts_flags;
    logic [7:0]        optional_header_length;
    logic              crc_present;
    logic              alignment_flag;
    logic              priority_flag;
  } res_t;

  // Up to two results per item, in order; v1 implies v0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic has_opt(input logic [7:0] id);
    return !(id inside {SID_PROG_MAP, SID_PADDING, SID_PRIV2, SID_ECM,
                        SID_EMM, SID_DSMCC, SID_H222_E, SID_PROG_DIR});
  endfunction

endpackage

[sv/pesr_if.sv]
// Interfaces: payload-byte input channel and result channel.
`timescale 1ns / 1ps

interface pesr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_payload;
  logic       unit_start;

  modport source (output valid, data_byte, first_of_payload, unit_start, input ready);
  modport sink   (input valid, data_byte, first_of_payload, unit_start, output ready);
endinterface

interface pesr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic [16:0] byte_offset;
  logic [7:0]  stream_ident;
  logic [15:0] declared_length;
  logic        has_optional_header;
  logic [1:0]  pts_dts_flags;
  logic [7:0]  optional_header_length;
  logic        crc_present;
  logic        alignment_flag;
  logic        priority_flag;

  modport source (output valid, kind, byte_out, byte_offset, stream_ident, declared_length,
                  has_optional_header, pts_dts_flags, optional_header_length,
                  crc_present, alignment_flag, priority_flag, input ready);
  modport sink   (input valid, kind, byte_out, byte_offset, stream_ident, declared_length,
                  has_optional_header, pts_dts_flags, optional_header_length,
                  crc_present, alignment_flag, priority_flag, output ready);
endinterface

[sv/pesr_core.sv]
// Reassembly core: input register, packet state and per-item result generation.
`timescale 1ns / 1ps

module pesr_core import pesr_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 65541
) (
  input  logic        clk,
  input  logic        rst_n,
  pesr_in_if.sink     in_chan,
  input  logic        space_ok,
  output push_t       push
);

  logic                  s1_v_r;
  logic [7:0]            s1_b_r;
  logic                  s1_first_r;
  logic                  s1_us_r;
  logic                  adv;

  logic [8:0][7:0]       hdr_r, hdr_nxt;
  logic [OFF_W-1:0]      bc_r, bc_nxt;
  logic [OFF_W-1:0]      tg_r, tg_nxt;
  logic                  storing_r, storing_nxt;
  logic                  skip_r, skip_nxt;

  logic                  pre_v, a_v, b_v;
  res_t                  pre_res, a_res, b_res;
  logic [HDR_IDX_W-1:0]  pos;
  logic [15:0]           len;

  function automatic res_t mk_res(input kind_t k, input logic [7:0] b,
                                  input logic [OFF_W-1:0] off, input logic ok,
                                  input logic [8:0][7:0] h);
    res_t r;
    r             = '0;
    r.kind        = k;
    r.byte_out    = b;
    r.byte_offset = off;
    if (ok) begin
      r.stream_ident    = h[3];
      r.declared_length = {h[4], h[5]};
      if (has_opt(h[3])) begin
        r.has_optional_header    = 1'b1;
        r.pts_dts_flags          = h[7][7:6];
        r.optional_header_length = h[8];
        r.crc_present            = h[7][1];
        r.alignment_flag         = h[6][2];
        r.priority_flag          = h[6][3];
      end
    end
    return r;
  endfunction

  function automatic logic hdr_ok(input logic [8:0][7:0] h);
    logic ok;
    ok = (h[0] == 8'h00) && (h[1] == 8'h00) && (h[2] == START_CODE_LAST);
    if (has_opt(h[3])) begin
      if ((h[6] & MARKER_MASK) != MARKER_VALUE) ok = 1'b0;
      if ((h[6] & SCRAMBLE_MASK) != 8'h00)      ok = 1'b0;
      if (h[7][7:6] == PTS_DTS_FORBIDDEN)       ok = 1'b0;
    end
    return ok;
  endfunction

  assign adv           = s1_v_r && space_ok;
  assign in_chan.ready = !s1_v_r || space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_b_r     <= in_chan.data_byte;
      s1_first_r <= in_chan.first_of_payload;
      s1_us_r    <= in_chan.unit_start;
    end
  end

  always_comb begin
    storing_nxt = storing_r;
    bc_nxt      = bc_r;
    tg_nxt      = tg_r;
    skip_nxt    = skip_r;
    hdr_nxt     = hdr_r;
    pre_v       = 1'b0;
    a_v         = 1'b0;
    b_v         = 1'b0;
    pre_res     = '0;
    a_res       = '0;
    b_res       = '0;
    pos         = '0;
    len         = '0;

    if (s1_first_r) skip_nxt = 1'b0;
    if (s1_first_r && s1_us_r) begin
      if (storing_r && tg_r == '0) begin
        pre_v   = 1'b1;
        pre_res = mk_res(KIND_COMMIT, 8'h00, bc_r, 1'b1, hdr_r);
      end else if (bc_r != '0) begin
        pre_v   = 1'b1;
        pre_res = mk_res(KIND_ABORT, 8'h00, bc_r, storing_r, hdr_r);
      end
      storing_nxt = 1'b0;
      bc_nxt      = '0;
      tg_nxt      = '0;
    end

    if (!skip_nxt) begin
      if (!storing_nxt) begin
        pos          = (bc_nxt >= OFF_W'(HDR_SIZE)) ? '0 : bc_nxt[HDR_IDX_W-1:0];
        hdr_nxt[pos] = s1_b_r;
        bc_nxt       = OFF_W'(pos) + OFF_W'(1);
        a_v          = 1'b1;
        if (pos != HDR_IDX_W'(HDR_SIZE - 1)) begin
          a_res = mk_res(KIND_BYTE, s1_b_r, OFF_W'(pos), 1'b0, hdr_nxt);
        end else if (!hdr_ok(hdr_nxt)) begin
          a_res    = mk_res(KIND_BYTE, s1_b_r, OFF_W'(pos), 1'b0, hdr_nxt);
          b_v      = 1'b1;
          b_res    = mk_res(KIND_ABORT, 8'h00, bc_nxt, 1'b0, hdr_nxt);
          bc_nxt   = '0;
          skip_nxt = 1'b1;
        end else begin
          len         = {hdr_nxt[4], hdr_nxt[5]};
          tg_nxt      = (len == 16'd0) ? '0 : OFF_W'(len) + OFF_W'(6);
          storing_nxt = 1'b1;
          a_res       = mk_res(KIND_BYTE, s1_b_r, OFF_W'(pos), 1'b1, hdr_nxt);
        end
      end else if (bc_nxt >= OFF_W'(MAX_PACKET_BYTES)) begin
        a_v         = 1'b1;
        a_res       = mk_res(KIND_ABORT, 8'h00, bc_nxt, 1'b1, hdr_nxt);
        storing_nxt = 1'b0;
        bc_nxt      = '0;
        tg_nxt      = '0;
        skip_nxt    = 1'b1;
      end else begin
        a_v    = 1'b1;
        a_res  = mk_res(KIND_BYTE, s1_b_r, bc_nxt, 1'b1, hdr_nxt);
        bc_nxt = OFF_W'(bc_nxt + OFF_W'(1));
      end

      // sized packet reaches its declared size
      if (storing_nxt && tg_nxt != '0 && bc_nxt == tg_nxt) begin
        b_v         = 1'b1;
        b_res       = mk_res(KIND_COMMIT, 8'h00, bc_nxt, 1'b1, hdr_nxt);
        storing_nxt = 1'b0;
        bc_nxt      = '0;
        tg_nxt      = '0;
        skip_nxt    = 1'b1;
      end
    end

    push = '0;
    if (adv) begin
      if (pre_v) begin
        push.v0 = 1'b1;
        push.r0 = pre_res;
        push.v1 = a_v;
        push.r1 = a_res;
      end else begin
        push.v0 = a_v;
        push.r0 = a_res;
        push.v1 = b_v;
        push.r1 = b_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      storing_r <= 1'b0;
      bc_r      <= '0;
      tg_r      <= '0;
      skip_r    <= 1'b0;
    end else if (adv) begin
      storing_r <= storing_nxt;
      bc_r      <= bc_nxt;
      tg_r      <= tg_nxt;
      skip_r    <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hdr_r <= hdr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
    !storing_r |-> (bc_r < OFF_W'(HDR_SIZE) && tg_r == '0))
    else $error("idle state holds a packet count or target");

  a_storing_past_header: assert property (@(posedge clk) disable iff (!rst_n)
    storing_r |-> bc_r >= OFF_W'(HDR_SIZE))
    else $error("storing before the header is complete");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && adv))
    else $error("second result pushed without the first");
`endif

endmodule

[sv/pesr_queue.sv]
// Result queue: takes up to two results a cycle, hands out one per handshake.
`timescale 1ns / 1ps

module pesr_queue import pesr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic        space_ok,
  pesr_out_if.source  out_chan
);

  res_t               mem [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]      cnt_r, cnt_nxt;
  logic               pop;
  logic [1:0]         n_push;
  res_t               head;

  assign pop      = out_chan.valid && out_chan.ready;
  assign n_push   = {1'b0, push.v0} + {1'b0, push.v1};
  assign space_ok = cnt_r <= (Q_AW+1)'(Q_DEPTH - 2);

  assign wr_ptr_nxt = Q_AW'(wr_ptr_r + Q_AW'(n_push));
  assign rd_ptr_nxt = Q_AW'(rd_ptr_r + Q_AW'(pop));
  assign cnt_nxt    = (Q_AW+1)'(cnt_r + (Q_AW+1)'(n_push) - (Q_AW+1)'(pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr_r] <= push.r0;
    if (push.v1) mem[Q_AW'(wr_ptr_r + Q_AW'(1))] <= push.r1;
  end

  assign head = mem[rd_ptr_r];

  assign out_chan.valid                  = cnt_r != '0;
  assign out_chan.kind                   = head.kind;
  assign out_chan.byte_out               = head.byte_out;
  assign out_chan.byte_offset            = head.byte_offset;
  assign out_chan.stream_ident           = head.stream_ident;
  assign out_chan.declared_length        = head.declared_length;
  assign out_chan.has_optional_header    = head.has_optional_header;
  assign out_chan.pts_dts_flags          = head.pts_dts_flags;
  assign out_chan.optional_header_length = head.optional_header_length;
  assign out_chan.crc_present            = head.crc_present;
  assign out_chan.alignment_flag         = head.alignment_flag;
  assign out_chan.priority_flag          = head.priority_flag;

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 || push.v1) |-> space_ok)
    else $error("results pushed into a queue without room");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

[sv/pes_packet_reassembler_top.sv]
// Top level of the PES packet reassembler: core plus result queue.
`timescale 1ns / 1ps

// PES packet reassembler. Takes transport-stream payload bytes, one item per
// handshake, each marked with first_of_payload and unit_start, gathers the
// nine-byte PES header, checks it (start code, marker bits, scrambling
// control, forbidden PTS_DTS_flags value) and echoes every stored byte with
// its offset in the packet. A packet ends with a commit result carrying its
// total size, or an abort result carrying the count stored so far. Sized
// packets commit when the count reaches PES_packet_length + 6; length-zero
// packets commit at the next unit start. After a commit or abort the rest of
// that transport payload is dropped without results. Declared lengths of 1
// or 2 never commit. A byte that would take the packet past
// MAX_PACKET_BYTES is replaced by an abort.
// Rate: one item per cycle while each item yields at most one result and the
// result port keeps up. An item with two results (unit-start commit or abort
// followed by the new header byte, bad header, or packet end) takes two
// handshakes of the result port, which drains one result per cycle while
// downstream is ready, from a four-entry queue; the input stalls only when
// that queue lacks room for two. An accepted item sits in the input register
// while the state update runs; its results enter the queue as the core
// advances. The queue decouples the result channel from the input, so a
// waiting result never blocks acceptance while there is room.
module pes_packet_reassembler_top import pesr_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 65541
) (
  input  logic        clk,
  input  logic        rst_n,
  pesr_in_if.sink     in_chan,
  pesr_out_if.source  out_chan
);

  push_t push;
  logic  space_ok;

  // Header check, packet counting and result generation
  pesr_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .space_ok (space_ok),
    .push     (push)
  );

  // Hold results until the downstream side takes them
  pesr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_chan (out_chan)
  );

endmodule

[tb/sv/tb.sv]
// Testbench of the PES packet reassembler: directed table and random PES streams.
`timescale 1ns / 1ps

// Drive transport payload bytes into the reassembler and check every result
// against a cycle-free predictor of the packet rebuilding rules. A short
// directed table comes first: the start of a good header, a length 3 packet
// that commits on its ninth byte, a bad start code, an interrupted partial
// header, and the extremes of the byte value. Some rows carry a hand-written
// kind and offset to cross-check the predictor itself. Random PES streams
// follow: mostly well-formed packets with random content, split into
// transport payloads of random size, mixed with corrupt headers, truncated
// packets, stuffing and loose noise. Both handshakes idle at random between
// items, with occasional rounds of no idling on either side.
module tb import pesr_pkg::*; ();

  localparam int unsigned MAX_BYTES     = 65541;
  localparam int unsigned ITEM_TARGET   = 650;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned N_DIRECTED    = 24;

  // One row of the directed table; pinned rows name a result the item must cause
  typedef struct packed {
    logic [7:0]  data;
    bit          first;
    bit          ustart;
    bit          pinned;
    kind_t       pin_kind;
    logic [16:0] pin_off;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pesr_in_if  in_chan ();
  pesr_out_if out_chan ();

  pes_packet_reassembler_top #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Two delays give a 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: header store, byte count, packet flags
  logic [7:0]  pes_hdr [HDR_SIZE];
  int unsigned stored_count  = 0;
  bit          in_packet     = 1'b0;
  int unsigned target_size   = 0;
  bit          skip_payload  = 1'b0;

  // Results still to come from the block, oldest first
  res_t        expected_results [$];
  // Results of the item just predicted, for the pinned rows
  res_t        item_results [2];
  int unsigned item_result_count;

  logic [7:0]  pes_bytes [$];
  int unsigned sent_items       = 0;
  int unsigned err_count        = 0;
  int unsigned cycle_count      = 0;
  bit          no_idle          = 1'b0;

  // Hand-checked rows: good header of length 3, bad start code, interrupted header
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h01, 1'b0, 1'b1, 1'b0, KIND_BYTE,   17'd0},
    '{8'hE0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, KIND_BYTE,   17'd0},
    '{8'h03, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h84, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h05, 1'b0, 1'b0, 1'b1, KIND_COMMIT, 17'd9},
    '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_BYTE,   17'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h02, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'hC0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, KIND_ABORT,  17'd9},
    '{8'h00, 1'b1, 1'b1, 1'b0, KIND_BYTE,   17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, KIND_BYTE,   17'd0},
    '{8'h5A, 1'b1, 1'b1, 1'b1, KIND_ABORT,  17'd3},
    '{8'hFF, 1'b0, 1'b0, 1'b1, KIND_BYTE,   17'd1}
  };

  initial begin
    for (int k = 0; k < HDR_SIZE; k++) pes_hdr[k] = 8'h00;
  end

  function automatic bit carries_opt_hdr(input logic [7:0] sid);
    case (sid)
      SID_PROG_MAP, SID_PADDING, SID_PRIV2, SID_ECM,
      SID_EMM, SID_DSMCC, SID_H222_E, SID_PROG_DIR: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic bit pes_header_good();
    if (pes_hdr[0] != 8'h00 || pes_hdr[1] != 8'h00 || pes_hdr[2] != START_CODE_LAST)
      return 1'b0;
    if (carries_opt_hdr(pes_hdr[3])) begin
      if ((pes_hdr[6] & MARKER_MASK) != MARKER_VALUE) return 1'b0;
      if ((pes_hdr[6] & SCRAMBLE_MASK) != 8'h00) return 1'b0;
      if (pes_hdr[7][7:6] == PTS_DTS_FORBIDDEN) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue one expected result; header fields only once a header has passed
  function automatic void add_result(input kind_t k, input logic [7:0] b,
                                     input int unsigned off, input bit hdr_valid);
    res_t r;
    r = '0;
    r.kind        = k;
    r.byte_out    = b;
    r.byte_offset = off[16:0];
    if (hdr_valid) begin
      r.stream_ident    = pes_hdr[3];
      r.declared_length = {pes_hdr[4], pes_hdr[5]};
      if (carries_opt_hdr(pes_hdr[3])) begin
        r.has_optional_header    = 1'b1;
        r.pts_dts_flags          = pes_hdr[7][7:6];
        r.optional_header_length = pes_hdr[8];
        r.crc_present            = pes_hdr[7][1];
        r.alignment_flag         = pes_hdr[6][2];
        r.priority_flag          = pes_hdr[6][3];
      end
    end
    expected_results.push_back(r);
    if (item_result_count < 2) item_results[item_result_count] = r;
    item_result_count++;
  endfunction

  function automatic void close_packet();
    in_packet    = 1'b0;
    stored_count = 0;
    target_size  = 0;
  endfunction

  // Advance the predictor by one accepted payload byte
  function automatic void predict_pes_byte(input logic [7:0] b, input bit first,
                                           input bit ustart);
    int unsigned pos;
    logic [15:0] len;
    item_result_count = 0;
    if (first) begin
      skip_payload = 1'b0;
      if (ustart) begin
        // a new unit ends whatever is open: unsized packets commit, others abort
        if (in_packet && target_size == 0)
          add_result(KIND_COMMIT, 8'h00, stored_count, 1'b1);
        else if (stored_count > 0)
          add_result(KIND_ABORT, 8'h00, stored_count, in_packet);
        close_packet();
      end
    end
    if (skip_payload) return;

    if (!in_packet) begin
      pos = stored_count;
      if (pos >= HDR_SIZE) pos = 0;
      pes_hdr[pos] = b;
      stored_count = pos + 1;
      if (stored_count < HDR_SIZE) begin
        add_result(KIND_BYTE, b, pos, 1'b0);
        return;
      end
      if (!pes_header_good()) begin
        add_result(KIND_BYTE, b, pos, 1'b0);
        add_result(KIND_ABORT, 8'h00, stored_count, 1'b0);
        stored_count = 0;
        skip_payload = 1'b1;
        return;
      end
      len = {pes_hdr[4], pes_hdr[5]};
      target_size = (len != 16'd0) ? int'(len) + 6 : 0;
      in_packet = 1'b1;
      add_result(KIND_BYTE, b, pos, 1'b1);
    end else begin
      if (stored_count >= MAX_BYTES) begin
        // byte would overflow the store: abort in its place
        add_result(KIND_ABORT, 8'h00, stored_count, 1'b1);
        close_packet();
        skip_payload = 1'b1;
        return;
      end
      add_result(KIND_BYTE, b, stored_count, 1'b1);
      stored_count++;
    end

    if (target_size != 0 && stored_count == target_size) begin
      add_result(KIND_COMMIT, 8'h00, stored_count, 1'b1);
      close_packet();
      skip_payload = 1'b1;
    end
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf({"kind %0d byte %h off %0d sid %h len %h opt %b pts %0d",
                      " hlen %h crc %b al %b pri %b"},
                     r.kind, r.byte_out, r.byte_offset, r.stream_ident, r.declared_length,
                     r.has_optional_header, r.pts_dts_flags, r.optional_header_length,
                     r.crc_present, r.alignment_flag, r.priority_flag);
  endfunction

  // Count every failure, report only the first few
  function automatic void note_failure(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Offer one item after a random gap and predict it once accepted
  task automatic send_item(input logic [7:0] b, input bit first, input bit ustart);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.data_byte        <= b;
    in_chan.first_of_payload <= first;
    in_chan.unit_start       <= ustart;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predict_pes_byte(b, first, ustart);
    sent_items++;
  endtask

  // Hold the input idle until every expected result has come, then settle
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Split pes_bytes into transport payloads of random size
  task automatic send_payloads(input bit ustart, input int unsigned max_chunk);
    int unsigned idx;
    int unsigned chunk;
    bit          first_chunk;
    idx = 0;
    first_chunk = 1'b1;
    while (idx < pes_bytes.size()) begin
      chunk = $urandom_range(1, max_chunk);
      for (int unsigned j = 0; j < chunk && idx < pes_bytes.size(); j++) begin
        if (j == 0) send_item(pes_bytes[idx], 1'b1, first_chunk ? ustart : 1'b0);
        else        send_item(pes_bytes[idx], 1'b0, 1'($urandom_range(0, 1)));
        idx++;
      end
      first_chunk = 1'b0;
    end
  endtask

  // Build one PES packet: mostly well formed, sometimes corrupt or truncated
  task automatic build_random_packet(output bit ustart);
    int unsigned pick;
    int unsigned body;
    int unsigned cut;
    logic [7:0]  sid;
    logic [7:0]  flags0;
    logic [7:0]  flags1;
    logic [15:0] len;
    pes_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 7))
        0: sid = SID_PROG_MAP;
        1: sid = SID_PADDING;
        2: sid = SID_PRIV2;
        3: sid = SID_ECM;
        4: sid = SID_EMM;
        5: sid = SID_DSMCC;
        6: sid = SID_H222_E;
        default: sid = SID_PROG_DIR;
      endcase
    end else if (pick < 25) begin
      sid = 8'($urandom);
    end else begin
      sid = 8'($urandom_range(8'hC0, 8'hEF));
    end

    pick = $urandom_range(0, 99);
    if (pick < 15)      len = 16'd0;
    else if (pick < 27) len = 16'($urandom_range(1, 3));
    else if (pick < 95) len = 16'($urandom_range(4, 48));
    else                len = 16'($urandom);

    // keep marker bits and clear scrambling most of the time
    flags0 = 8'($urandom);
    if ($urandom_range(0, 99) < 85) flags0 = {2'b10, 2'b00, flags0[3:0]};
    flags1 = 8'($urandom);
    if (flags1[7:6] == PTS_DTS_FORBIDDEN && $urandom_range(0, 3) != 0) flags1[7:6] = 2'b10;

    pes_bytes = '{8'h00, 8'h00, START_CODE_LAST, sid, len[15:8], len[7:0],
                  flags0, flags1, 8'($urandom)};
    if ($urandom_range(0, 19) == 0) pes_bytes[$urandom_range(0, 2)] = 8'($urandom);

    body = (len >= 16'd3 && len <= 16'd48) ? int'(len) - 3 : $urandom_range(0, 40);
    repeat (body) pes_bytes.push_back(8'($urandom));

    // truncate now and then so the next unit start interrupts the packet
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, pes_bytes.size());
      while (pes_bytes.size() > cut) void'(pes_bytes.pop_back());
    end
    if ($urandom_range(0, 1) == 1)
      repeat ($urandom_range(0, 5)) pes_bytes.push_back(($urandom_range(0, 1) == 1) ?
                                                        8'hFF : 8'($urandom));
    ustart = ($urandom_range(0, 9) != 0);
  endtask

  // Result side: stall at random, then compare each item with the oldest expectation
  initial begin
    res_t        got;
    res_t        want;
    int unsigned stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      got.kind                   = kind_t'(out_chan.kind);
      got.byte_out               = out_chan.byte_out;
      got.byte_offset            = out_chan.byte_offset;
      got.stream_ident           = out_chan.stream_ident;
      got.declared_length        = out_chan.declared_length;
      got.has_optional_header    = out_chan.has_optional_header;
      got.pts_dts_flags          = out_chan.pts_dts_flags;
      got.optional_header_length = out_chan.optional_header_length;
      got.crc_present            = out_chan.crc_present;
      got.alignment_flag         = out_chan.alignment_flag;
      got.priority_flag          = out_chan.priority_flag;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: %s", describe(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          note_failure($sformatf("mismatch\n  expected %s\n  actual   %s",
                                 describe(want), describe(got)));
      end
    end
  end

  // Watchdog: end the run with a failure once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    bit        found;
    bit        ustart;
    int unsigned round;
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.data_byte        <= 8'h00;
    in_chan.first_of_payload <= 1'b0;
    in_chan.unit_start       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; pinned rows also cross-check the predictor
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      send_item(row.data, row.first, row.ustart);
      if (row.pinned) begin
        found = 1'b0;
        for (int j = 0; j < item_result_count && j < 2; j++)
          if (item_results[j].kind == row.pin_kind && item_results[j].byte_offset == row.pin_off)
            found = 1'b1;
        if (!found)
          note_failure($sformatf("directed item %0d: no kind %0d result at offset %0d",
                                 i, row.pin_kind, row.pin_off));
      end
    end
    drain_results();

    // Random PES streams until enough items have been sent
    round = 0;
    while (sent_items < ITEM_TARGET) begin
      round++;
      no_idle = ($urandom_range(0, 7) == 0);
      if (round == 12) drain_results();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        build_random_packet(ustart);
        send_payloads(ustart, $urandom_range(1, 30));
      end
    end
    no_idle = 1'b0;

    drain_results();
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/pesr_pkg.sv
sv/pesr_if.sv
sv/pesr_core.sv
sv/pesr_queue.sv
sv/pes_packet_reassembler_top.sv
tb/sv/tb.sv
